>>> src/etq_pkg.sv
`default_nettype none
package etq_pkg;

    localparam logic [2:0] KIND_SET  = 3'd0;
    localparam logic [2:0] KIND_GET  = 3'd1;
    localparam logic [2:0] KIND_DEL  = 3'd2;
    localparam logic [2:0] KIND_NEXT = 3'd3;
    localparam logic [2:0] KIND_POP  = 3'd4;
    localparam logic [2:0] KIND_TICK = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    // Which result the output register is loaded with.
    typedef enum logic [2:0] {
        RES_NONE = 3'd0,
        RES_FULL = 3'd1,
        RES_MISS = 3'd2,
        RES_GET  = 3'd3,
        RES_NEXT = 3'd4,
        RES_POP  = 3'd5
    } t_res;

    typedef struct packed {
        logic clr;
        logic latch;
        logic tick;
        logic krd;
        logic kset;
        logic kdel;
        logic ins_init;
        logic ins_rd;
        logic ins_shift;
        logic ins_put;
        logic prd;
        logic pmeta;
        logic pdrop;
        logic pkill;
        logic out_load;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       full;
        logic       empty;
        logic       pos_zero;
        logic       later;
        logic       key_live;
        logic       entry_live;
        logic [2:0] kind;
    } t_sts;

endpackage
`default_nettype wire

>>> src/etq_dpath.sv
`default_nettype none
module etq_dpath #(
    parameter int KEY_COUNT    = 256,
    parameter int HEAP_DEPTH   = 512,
    parameter int VERSION_BITS = 16,
    parameter int TIME_BITS    = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire etq_pkg::t_cmd        i_cmd,
    output etq_pkg::t_sts             o_sts,
    input  wire logic [2:0]           i_kind,
    input  wire logic [7:0]           i_key_id,
    input  wire logic [31:0]          i_ttl_ms,
    output logic [1:0]                o_status,
    output logic                      o_found,
    output logic [TIME_BITS-1:0]      o_time_ms,
    output logic [7:0]                o_key_out
);

    localparam int KW = $clog2(KEY_COUNT);
    localparam int HW = $clog2(HEAP_DEPTH);
    localparam int FW = $clog2(HEAP_DEPTH + 1);
    localparam int VB = VERSION_BITS;
    localparam int TB = TIME_BITS;
    localparam int MW = 1 + VB;
    localparam int EW = TB + KW + VB;

    typedef logic [KW-1:0] t_kmap [256];

    function automatic t_kmap key_map_f();
        t_kmap m;
        for (int i = 0; i < 256; i++) begin
            m[i] = KW'(i % KEY_COUNT);
        end
        return m;
    endfunction

    localparam t_kmap KEY_MAP = key_map_f();

    // Logical queue position to physical slot of the circular buffer.
    function automatic logic [HW-1:0] phys_f(input logic [HW-1:0] head,
                                             input logic [FW-1:0] pos);
        logic [FW:0] s;
        s = (FW+1)'(head) + (FW+1)'(pos);
        if (s >= (FW+1)'(HEAP_DEPTH)) begin
            s = s - (FW+1)'(HEAP_DEPTH);
        end
        return s[HW-1:0];
    endfunction

    logic [KW-1:0] r_key;
    logic [31:0]   r_ttl;
    logic [2:0]    r_kind;
    logic [TB-1:0] r_clock;
    logic [KW-1:0] r_clr_addr;
    logic [MW-1:0] r_meta_q;
    logic [TB-1:0] r_exp_q;
    logic [EW-1:0] r_heap_q;
    logic [TB-1:0] r_new_time;
    logic [VB-1:0] r_new_ver;
    logic [FW-1:0] r_fill;
    logic [HW-1:0] r_head;
    logic [FW-1:0] r_pos;

    logic [MW-1:0] r_meta_mem [KEY_COUNT];
    logic [TB-1:0] r_exp_mem  [KEY_COUNT];
    logic [EW-1:0] r_heap_mem [HEAP_DEPTH];

    logic [TB:0]   sum;
    logic [TB-1:0] exp_now;
    logic [VB-1:0] ver_next;
    logic [KW-1:0] heap_key;
    logic [VB-1:0] heap_ver;
    logic [TB-1:0] heap_time;

    logic          meta_we;
    logic [KW-1:0] meta_waddr;
    logic [MW-1:0] meta_wdata;
    logic [KW-1:0] meta_raddr;
    logic          heap_we;
    logic [HW-1:0] heap_waddr;
    logic [EW-1:0] heap_wdata;
    logic [HW-1:0] heap_raddr;
    logic [KW+7:0] key_ext;

    assign sum       = {1'b0, r_clock} + (TB+1)'(r_ttl);
    assign exp_now   = sum[TB] ? '1 : sum[TB-1:0];
    assign ver_next  = r_meta_q[VB-1:0] + 1'b1;
    assign heap_time = r_heap_q[EW-1 -: TB];
    assign heap_key  = r_heap_q[VB +: KW];
    assign heap_ver  = r_heap_q[VB-1:0];
    assign key_ext   = (KW+8)'(heap_key);

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = r_key;
        meta_wdata = {1'b0, r_meta_q[VB-1:0]};
        if (i_cmd.clr) begin
            meta_we    = 1'b1;
            meta_waddr = r_clr_addr;
            meta_wdata = '0;
        end else if (i_cmd.kset) begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, ver_next};
        end else if (i_cmd.kdel) begin
            meta_we    = 1'b1;
        end else if (i_cmd.pkill) begin
            meta_we    = 1'b1;
            meta_waddr = heap_key;
        end
        meta_raddr = i_cmd.pmeta ? heap_key : r_key;
    end

    always_comb begin
        heap_we    = i_cmd.ins_shift | i_cmd.ins_put;
        heap_waddr = phys_f(r_head, r_pos);
        heap_wdata = i_cmd.ins_shift ? r_heap_q : {r_new_time, r_key, r_new_ver};
        heap_raddr = i_cmd.prd ? r_head : phys_f(r_head, r_pos - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_waddr] <= meta_wdata;
        end
        if (i_cmd.krd || i_cmd.pmeta) begin
            r_meta_q <= r_meta_mem[meta_raddr];
        end
        if (i_cmd.kset) begin
            r_exp_mem[r_key] <= exp_now;
        end
        if (i_cmd.krd) begin
            r_exp_q <= r_exp_mem[r_key];
        end
        if (heap_we) begin
            r_heap_mem[heap_waddr] <= heap_wdata;
        end
        if (i_cmd.ins_rd || i_cmd.prd) begin
            r_heap_q <= r_heap_mem[heap_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_fill     <= '0;
            r_head     <= '0;
            r_clr_addr <= '0;
            r_pos      <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.tick) begin
                r_clock <= r_clock + 1'b1;
            end
            if (i_cmd.ins_init) begin
                r_pos <= r_fill;
            end else if (i_cmd.ins_shift) begin
                r_pos <= r_pos - 1'b1;
            end
            if (i_cmd.ins_put) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.pdrop) begin
                r_fill <= r_fill - 1'b1;
                r_head <= (r_head == HW'(HEAP_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_key  <= KEY_MAP[i_key_id];
            r_ttl  <= i_ttl_ms;
        end
        if (i_cmd.kset) begin
            r_new_time <= exp_now;
            r_new_ver  <= ver_next;
        end
        if (i_cmd.out_load) begin
            o_status  <= etq_pkg::STATUS_OK;
            o_found   <= 1'b0;
            o_time_ms <= '0;
            o_key_out <= '0;
            case (i_cmd.res)
                etq_pkg::RES_FULL: o_status <= etq_pkg::STATUS_FULL;
                etq_pkg::RES_MISS: o_status <= etq_pkg::STATUS_MISS;
                etq_pkg::RES_GET: begin
                    o_found   <= 1'b1;
                    o_time_ms <= r_exp_q;
                end
                etq_pkg::RES_NEXT: begin
                    o_found   <= 1'b1;
                    o_time_ms <= heap_time;
                end
                etq_pkg::RES_POP: begin
                    o_found   <= 1'b1;
                    o_time_ms <= heap_time;
                    o_key_out <= key_ext[7:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.clr_last   = (r_clr_addr == KW'(KEY_COUNT - 1));
        o_sts.full       = (r_fill == FW'(HEAP_DEPTH));
        o_sts.empty      = (r_fill == '0);
        o_sts.pos_zero   = (r_pos == '0);
        o_sts.later      = (heap_time > r_new_time);
        o_sts.key_live   = r_meta_q[VB];
        o_sts.entry_live = r_meta_q[VB] && (r_meta_q[VB-1:0] == heap_ver);
        o_sts.kind       = r_kind;
    end

endmodule
`default_nettype wire

>>> src/etq_ctrl.sv
`default_nettype none
module etq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0]    i_kind,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire etq_pkg::t_sts i_sts,
    output etq_pkg::t_cmd      o_cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_KRD   = 10'b0000000100,
        ST_KEXE  = 10'b0000001000,
        ST_IRD   = 10'b0000010000,
        ST_ICMP  = 10'b0000100000,
        ST_PRD   = 10'b0001000000,
        ST_PWAIT = 10'b0010000000,
        ST_PCHK  = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } t_state;

    t_state        r_state, n_state;
    etq_pkg::t_res r_res, n_res;
    logic          r_valid, n_valid;

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        o_cmd.res = r_res;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_res       = etq_pkg::RES_NONE;
                    unique case (i_kind) inside
                        etq_pkg::KIND_SET, etq_pkg::KIND_GET, etq_pkg::KIND_DEL:
                            n_state = ST_KRD;
                        etq_pkg::KIND_NEXT, etq_pkg::KIND_POP:
                            n_state = ST_PRD;
                        etq_pkg::KIND_TICK: begin
                            o_cmd.tick = 1'b1;
                            n_state    = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_KRD: begin
                o_cmd.krd = 1'b1;
                n_state   = ST_KEXE;
            end
            ST_KEXE: begin
                n_state = ST_DONE;
                case (i_sts.kind)
                    etq_pkg::KIND_SET: begin
                        o_cmd.kset = 1'b1;
                        if (i_sts.full) begin
                            n_res = etq_pkg::RES_FULL;
                        end else begin
                            o_cmd.ins_init = 1'b1;
                            n_state        = ST_IRD;
                        end
                    end
                    etq_pkg::KIND_GET:
                        n_res = i_sts.key_live ? etq_pkg::RES_GET : etq_pkg::RES_MISS;
                    default: o_cmd.kdel = 1'b1;
                endcase
            end
            ST_IRD: begin
                if (i_sts.pos_zero) begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = ST_ICMP;
                end
            end
            ST_ICMP: begin
                if (i_sts.later) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = ST_IRD;
                end else begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_PRD: begin
                if (i_sts.empty) begin
                    n_res   = etq_pkg::RES_MISS;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.prd = 1'b1;
                    n_state   = ST_PWAIT;
                end
            end
            ST_PWAIT: begin
                o_cmd.pmeta = 1'b1;
                n_state     = ST_PCHK;
            end
            ST_PCHK: begin
                if (i_sts.entry_live) begin
                    n_state = ST_DONE;
                    if (i_sts.kind == etq_pkg::KIND_POP) begin
                        o_cmd.pkill = 1'b1;
                        o_cmd.pdrop = 1'b1;
                        n_res       = etq_pkg::RES_POP;
                    end else begin
                        n_res = etq_pkg::RES_NEXT;
                    end
                end else begin
                    o_cmd.pdrop = 1'b1;
                    n_state     = ST_PRD;
                end
            end
            ST_DONE: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_valid <= 1'b0;
            r_res   <= etq_pkg::RES_NONE;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_res   <= n_res;
        end
    end

endmodule
`default_nettype wire

>>> src/expiry_timer_queue_top.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_kind, i_key_id, i_ttl_ms
// result    out        o_valid / i_stall  o_status, o_found, o_time_ms, o_key_out
//
// One request is worked at a time; the next is taken while its result still waits.
// Set reports full on a full queue; else, working from the tail, it moves each entry that
// expires later back by one and puts the new entry where an entry that is not later, or the
// front, ends the search. Next and pop drop stale front entries until a live one is found,
// or report a miss when the queue runs empty. After reset a clearing pass zeroes the key
// table and no request is taken during it. A stalled result holds in the output register.
module expiry_timer_queue_top #(
    parameter int KEY_COUNT    = 256,
    parameter int HEAP_DEPTH   = 512,
    parameter int VERSION_BITS = 16,
    parameter int TIME_BITS    = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [2:0]           i_kind,
    input  wire logic [7:0]           i_key_id,
    input  wire logic [31:0]          i_ttl_ms,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [1:0]                o_status,
    output logic                      o_found,
    output logic [TIME_BITS-1:0]      o_time_ms,
    output logic [7:0]                o_key_out
);

    // The controller sequences each request; the datapath holds the key table,
    // the expiry table and the queue, kept sorted as a circular buffer.
    etq_pkg::t_cmd cmd;
    etq_pkg::t_sts sts;

    etq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_kind  (i_kind),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    etq_dpath #(
        .KEY_COUNT    (KEY_COUNT),
        .HEAP_DEPTH   (HEAP_DEPTH),
        .VERSION_BITS (VERSION_BITS),
        .TIME_BITS    (TIME_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_kind    (i_kind),
        .i_key_id  (i_key_id),
        .i_ttl_ms  (i_ttl_ms),
        .o_status  (o_status),
        .o_found   (o_found),
        .o_time_ms (o_time_ms),
        .o_key_out (o_key_out)
    );

    // An accepted request keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted but block not busy");

    // The queue cannot be both full and empty.
    a_fill_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sts.full && sts.empty))
        else $error("queue fill count inconsistent");

    // A result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !cmd.out_load)
        else $error("pending result overwritten");

endmodule
`default_nettype wire
